>>> src/brrc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brrc_pkg
// Shared types and constants of the byte-range read cache slot table.
// ---------------------------------------------------------------------------
package brrc_pkg;

	localparam int unsigned SLOTS_DEFAULT = 8;
	localparam int unsigned OFS_W = 48;
	localparam int unsigned LEN_W = 25;
	localparam int unsigned HINT_SPAN_SHIFT = 2;
	localparam logic [LEN_W-1:0] CHUNK_RESET = 25'd262144;

	typedef enum logic [2:0] {
		OP_LOOKUP   = 3'd0,
		OP_AHEAD    = 3'd1,
		OP_ISSUE    = 3'd2,
		OP_COMPLETE = 3'd3,
		OP_RELEASE  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_WAIT     = 3'd1,
		ST_PLANNED  = 3'd2,
		ST_DECLINED = 3'd3,
		ST_ISSUED   = 3'd4,
		ST_DONE     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		REG_CHUNK = 2'd0,
		REG_REUSE = 2'd1
	} reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LK_CONS,
		S_LK_HIT,
		S_LK_WAIT,
		S_LK_CLIP,
		S_RA_FREE,
		S_RA_SKIP,
		S_RA_CLIP,
		S_FINISH,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  source_id;
		logic [47:0] req_offset;
		logic [47:0] req_end;
		logic [7:0]  slot_hint;
		logic [47:0] hint_min_offset;
		logic [7:0]  hint_min_slot;
		logic [15:0] align_mask;
		logic [47:0] source_last;
		logic [5:0]  done_slot;
		logic [24:0] landed_size;
		logic        landed_has_buffer;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  slot;
		logic [23:0] data_offset;
		logic [24:0] avail_size;
		logic [7:0]  read_source;
		logic [47:0] read_offset;
		logic [24:0] rd_size;
		logic        use_own_buffer;
	} rsp_t;

endpackage

>>> src/brrc_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brrc_if
// Valid/ready channel carrying one payload of a given type.
// ---------------------------------------------------------------------------
interface brrc_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/byte_range_read_cache_slots_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// byte_range_read_cache_slots_core
// Slot table of cached byte ranges with lookup, read-ahead, issue, completion
// and release operations, worked through one slot per cycle.
// ---------------------------------------------------------------------------
// Channel  Dir  Type   Content
// req      in   req_t  operation and its operands
// rsp      out  rsp_t  status and result fields
// apb      in   -      read_chunk_size at 0x0, reuse_enable at 0x4
//
// A lookup visits the slots in three passes plus a clip pass. A read-ahead
// picks a slot in a pass over the slots, then makes up to SLOTS+1 skipping
// passes and a clip pass. Issue, completion and release go from S_IDLE
// through S_FINISH to S_OUT. One comparator walks the slot table under the
// sequencer; the next transfer is taken only after the result is taken.
// arst_n clears the table and the pending plan and sets the registers to their reset values.
// ---------------------------------------------------------------------------
module byte_range_read_cache_slots_core #(
	parameter int unsigned SLOTS = brrc_pkg::SLOTS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	brrc_if.sink        req,
	brrc_if.source      rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import brrc_pkg::*;

	localparam int unsigned SW = $clog2(SLOTS);
	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam int unsigned RW = $clog2(SLOTS + 2);
	localparam int unsigned SEL_RECIP = (65536 + SLOTS - 1) / SLOTS;

	logic [LEN_W-1:0] chunk_q;
	logic             reuse_q;

	logic             used_q [SLOTS];
	logic [7:0]       owner_q [SLOTS];
	logic [OFS_W-1:0] start_q [SLOTS];
	logic [OFS_W-1:0] end_q [SLOTS];
	logic [LEN_W-1:0] ext_q [SLOTS];
	logic [OFS_W-1:0] cons_q [SLOTS];
	logic             busy_q [SLOTS];
	logic             buf_q [SLOTS];
	logic             pend_q;
	logic [SW-1:0]    pslot_q;

	state_t           state_q, state_d;
	req_t             r_q;
	rsp_t             o_q;
	logic [CW-1:0]    k_q;
	logic [RW-1:0]    round_q;
	logic             moved_q, found_q;
	logic [SW-1:0]    t_q;
	logic [OFS_W-1:0] pos_q;
	logic [OFS_W:0]   len_q;
	logic [OFS_W-1:0] am48;
	logic [OFS_W:0]   am49;

	assign am48 = {32'd0, r_q.align_mask};
	assign am49 = {33'd0, r_q.align_mask};
	assign pready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_OUT);
	assign rsp.data = o_q;

	always_comb begin
		prdata = 32'd0;
		case (paddr[2])
			1'b0: prdata = {7'd0, chunk_q};
			default: prdata = {31'd0, reuse_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= CHUNK_RESET;
			reuse_q <= 1'b1;
		end else if (psel && penable && pwrite) begin
			if (paddr == {1'(REG_CHUNK), 2'b00})
				chunk_q <= pwdata[LEN_W-1:0];
			else if (paddr == {1'(REG_REUSE), 2'b00})
				reuse_q <= pwdata[0];
		end
	end

	// Current slot under the scan and derived values.
	logic [SW-1:0]    k;
	logic             own_k, last_k;
	logic [OFS_W:0]   reach_k, sext_k;
	assign k = k_q[SW-1:0];
	assign own_k = used_q[k] && owner_q[k] == r_q.source_id;
	assign sext_k = {1'b0, start_q[k]} + {24'd0, ext_q[k]};
	assign reach_k = busy_q[k] ? sext_k : {1'b0, end_q[k]};
	assign last_k = (k_q == CW'(SLOTS - 1));

	// Hint rule and target selection for a lookup plan.
	logic [OFS_W-1:0] hmo_al, lk_pos;
	logic [OFS_W:0]   hmo_span, hmo_top;
	logic             use_hint;
	logic [7:0]       lk_sel;
	logic [SW-1:0]    lk_t;
	assign hmo_span = {1'b0, r_q.hint_min_offset}
		+ {26'd0, chunk_q[LEN_W-1:HINT_SPAN_SHIFT]};
	assign hmo_al = r_q.hint_min_offset & ~am48;
	assign hmo_top = {1'b0, hmo_al} + {24'd0, chunk_q};
	assign use_hint = r_q.hint_min_offset < r_q.req_offset
		&& hmo_span > {1'b0, r_q.req_offset}
		&& {1'b0, r_q.req_end} < hmo_top;
	assign lk_pos = (use_hint ? r_q.hint_min_offset : r_q.req_offset) & ~am48;
	assign lk_sel = use_hint ? r_q.hint_min_slot : r_q.slot_hint;

	// The slot hint modulo SLOTS, by reciprocal multiplication.
	logic [23:0] sel_prod;
	logic [7:0]  sel_quot, sel_rem;
	assign sel_prod = {16'd0, lk_sel} * 24'(SEL_RECIP);
	assign sel_quot = sel_prod[23:16];
	assign sel_rem = lk_sel - 8'(16'(sel_quot) * 16'(SLOTS));
	assign lk_t = SW'(sel_rem);

	logic [OFS_W-1:0] diff_k, top_al;
	logic [OFS_W:0]   al_last, al_gap;
	assign al_last = ({1'b0, r_q.source_last} + am49) & ~am49;
	assign al_gap = al_last - {1'b0, pos_q};
	assign diff_k = start_q[k] - pos_q;
	assign top_al = reach_k[OFS_W-1:0] & ~am48;

	logic idle_k;
	assign idle_k = !busy_q[k] && (!used_q[k] || end_q[k] <= cons_q[k]);

	logic skip_hit;
	assign skip_hit = k != t_q && own_k && start_q[k] <= pos_q
		&& {1'b0, pos_q} < reach_k;

	logic [OFS_W:0] pos_len;
	assign pos_len = {1'b0, pos_q} + len_q;

	logic lk_clip;
	assign lk_clip = pos_len > {1'b0, r_q.source_last} && al_last > {1'b0, pos_q}
		&& al_gap < len_q;

	logic [OFS_W:0] ra_len;
	assign ra_len = (k_q == '0 && len_q > {24'd0, chunk_q}) ? {24'd0, chunk_q} : len_q;

	logic [SW-1:0] ds;
	assign ds = r_q.done_slot[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q <= 1'b0;
			pslot_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				used_q[i] <= 1'b0;
				owner_q[i] <= '0;
				start_q[i] <= '0;
				end_q[i] <= '0;
				ext_q[i] <= '0;
				cons_q[i] <= '0;
				busy_q[i] <= 1'b0;
				buf_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						r_q <= req.data;
						k_q <= '0;
						round_q <= '0;
						moved_q <= 1'b0;
						found_q <= 1'b0;
						o_q <= '{status: ST_DECLINED, default: '0};
					end
				end
				S_LK_CONS: begin
					if (own_k) cons_q[k] <= r_q.req_offset;
					k_q <= last_k ? '0 : k_q + 1'b1;
				end
				S_LK_HIT: begin
					if (o_q.status != ST_HIT && !busy_q[k] && own_k
						&& r_q.req_offset >= start_q[k] && r_q.req_offset < end_q[k]) begin
						o_q.status <= ST_HIT;
						o_q.slot <= 6'(k);
						o_q.data_offset <= 24'(r_q.req_offset - start_q[k]);
						o_q.avail_size <= 25'(end_q[k] - r_q.req_offset);
					end
					k_q <= last_k ? '0 : k_q + 1'b1;
					pos_q <= lk_pos;
					len_q <= {24'd0, chunk_q};
					t_q <= lk_t;
				end
				S_LK_WAIT: begin
					if (busy_q[k] && own_k && r_q.req_offset >= start_q[k]
						&& {1'b0, r_q.req_offset} < sext_k) begin
						pend_q <= 1'b0;
						o_q.status <= ST_WAIT;
						o_q.slot <= 6'(k);
					end else if (last_k && busy_q[t_q]) begin
						pend_q <= 1'b0;
						o_q.status <= ST_WAIT;
						o_q.slot <= 6'(t_q);
					end
					k_q <= last_k ? '0 : k_q + 1'b1;
				end
				S_LK_CLIP: begin
					if (k != t_q && own_k) begin
						if (start_q[k] > pos_q) begin
							if ({1'b0, diff_k} < len_q) len_q <= {1'b0, diff_k};
						end else if (reach_k > {1'b0, pos_q}) begin
							pos_q <= top_al;
						end
					end
					k_q <= last_k ? '0 : k_q + 1'b1;
				end
				S_RA_FREE: begin
					if (idle_k && (!found_q || (!buf_q[t_q] && buf_q[k]))) begin
						t_q <= k;
						found_q <= 1'b1;
					end
					pos_q <= r_q.req_offset & ~am48;
					k_q <= last_k ? '0 : k_q + 1'b1;
				end
				S_RA_SKIP: begin
					if (skip_hit) begin
						if (top_al <= pos_q) begin
							found_q <= 1'b0;
						end else begin
							pos_q <= top_al;
						end
					end
					if (last_k) begin
						k_q <= '0;
						moved_q <= 1'b0;
						round_q <= round_q + 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
						if (skip_hit && top_al > pos_q) moved_q <= 1'b1;
					end
					len_q <= al_gap;
				end
				S_RA_CLIP: begin
					if (k != t_q && own_k && start_q[k] > pos_q
						&& {1'b0, diff_k} < ra_len)
						len_q <= {1'b0, diff_k};
					else
						len_q <= ra_len;
					k_q <= last_k ? '0 : k_q + 1'b1;
				end
				S_FINISH: begin
					case (r_q.op)
						OP_LOOKUP, OP_AHEAD: begin
							if (r_q.op == OP_LOOKUP && lk_clip)
								len_q <= al_gap;
							if (o_q.status == ST_DECLINED && (r_q.op == OP_LOOKUP
								|| (found_q && len_q != '0))) begin
								used_q[t_q] <= 1'b1;
								owner_q[t_q] <= r_q.source_id;
								start_q[t_q] <= pos_q;
								cons_q[t_q] <= r_q.req_offset;
								pend_q <= 1'b1;
								pslot_q <= t_q;
								o_q.status <= ST_PLANNED;
								o_q.slot <= 6'(t_q);
								if (r_q.op == OP_LOOKUP && lk_clip)
									ext_q[t_q] <= al_gap[LEN_W-1:0];
								else
									ext_q[t_q] <= len_q[LEN_W-1:0];
							end
						end
						OP_ISSUE: begin
							if (pend_q) begin
								o_q.status <= ST_ISSUED;
								o_q.slot <= 6'(pslot_q);
								o_q.read_source <= used_q[pslot_q] ? owner_q[pslot_q] : 8'd0;
								o_q.read_offset <= start_q[pslot_q];
								o_q.rd_size <= ext_q[pslot_q];
								o_q.use_own_buffer <= reuse_q && buf_q[pslot_q];
								busy_q[pslot_q] <= 1'b1;
								pend_q <= 1'b0;
							end
						end
						OP_COMPLETE: begin
							o_q.status <= ST_DONE;
							o_q.slot <= r_q.done_slot;
							if (32'(r_q.done_slot) < SLOTS) begin
								buf_q[ds] <= r_q.landed_has_buffer;
								ext_q[ds] <= r_q.landed_size;
								end_q[ds] <= start_q[ds] + {23'd0, r_q.landed_size};
								busy_q[ds] <= 1'b0;
							end
						end
						OP_RELEASE: begin
							o_q.status <= ST_DONE;
							for (int i = 0; i < SLOTS; i++) begin
								if (!busy_q[i]) begin
									used_q[i] <= 1'b0;
									owner_q[i] <= '0;
									start_q[i] <= '0;
									end_q[i] <= '0;
									cons_q[i] <= '0;
								end
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (req.valid) begin
				case (req.data.op)
					OP_LOOKUP: state_d = S_LK_CONS;
					OP_AHEAD: state_d = pend_q ? S_OUT : S_RA_FREE;
					OP_ISSUE, OP_COMPLETE, OP_RELEASE: state_d = S_FINISH;
					default: state_d = S_OUT;
				endcase
			end
			S_LK_CONS: if (last_k) state_d = S_LK_HIT;
			S_LK_HIT: if (last_k) state_d = (o_q.status == ST_HIT
				|| (!busy_q[k] && own_k && r_q.req_offset >= start_q[k]
				&& r_q.req_offset < end_q[k])) ? S_OUT : S_LK_WAIT;
			S_LK_WAIT: begin
				if (busy_q[k] && own_k && r_q.req_offset >= start_q[k]
					&& {1'b0, r_q.req_offset} < sext_k) state_d = S_OUT;
				else if (last_k) state_d = busy_q[t_q] ? S_OUT : S_LK_CLIP;
			end
			S_LK_CLIP: if (last_k) state_d = S_FINISH;
			S_RA_FREE: if (last_k)
				state_d = (found_q || idle_k) ? S_RA_SKIP : S_OUT;
			S_RA_SKIP: begin
				if (skip_hit && top_al <= pos_q) state_d = S_OUT;
				else if (last_k) begin
					if (!(moved_q || skip_hit))
						state_d = (pos_q >= r_q.source_last) ? S_OUT : S_RA_CLIP;
					else if (round_q == RW'(SLOTS)) state_d = S_OUT;
				end
			end
			S_RA_CLIP: if (last_k) state_d = S_FINISH;
			S_FINISH: state_d = S_OUT;
			S_OUT: if (rsp.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("result changed while stalled");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("request taken while result waits");
	a_issue_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == ST_ISSUED |-> !pend_q)
		else $error("plan still pending after issue");
	a_plan_sets: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == ST_PLANNED |-> pend_q)
		else $error("planned read without pending plan");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte-range read cache slot table.
// Requests are driven over the request channel and the register port. An
// internal copy of the slot table predicts each response, and the responses
// are compared field by field in order of arrival.
// ---------------------------------------------------------------------------
module testbench;
	import brrc_pkg::*;

	localparam int unsigned NSLOT = SLOTS_DEFAULT;
	localparam longint unsigned M48 = 48'hFFFF_FFFF_FFFF;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int QUIET_TAIL = 150;

	typedef longint unsigned u64;

	class slot_table_tracker;
		u64 chunk;
		bit reuse;
		bit used[NSLOT];
		u64 owner[NSLOT];
		u64 start[NSLOT];
		u64 send[NSLOT];
		u64 ext[NSLOT];
		u64 cons[NSLOT];
		bit busy[NSLOT];
		bit has_buf[NSLOT];
		bit plan_valid;
		int plan_slot;
		rsp_t expected_rsp[$];
		int errors;
		int checked;
		int hits, waits, plans, issues;

		function new();
			chunk = CHUNK_RESET;
			reuse = 1;
			foreach (used[k]) begin
				used[k] = 0; owner[k] = 0; start[k] = 0; send[k] = 0;
				ext[k] = 0; cons[k] = 0; busy[k] = 0; has_buf[k] = 0;
			end
			plan_valid = 0;
			plan_slot = 0;
			errors = 0;
			checked = 0;
		endfunction

		function bit owned(int k, u64 src);
			return used[k] && owner[k] == src;
		endfunction

		function u64 reach(int k);
			return busy[k] ? start[k] + ext[k] : send[k];
		endfunction

		function void claim(int t, u64 src, u64 pos, u64 len, u64 c);
			used[t] = 1;
			owner[t] = src;
			start[t] = pos & M48;
			ext[t] = len & 25'h1FF_FFFF;
			cons[t] = c & M48;
			plan_valid = 1;
			plan_slot = t;
		endfunction

		function void lookup(req_t r, ref rsp_t o);
			u64 src, roff, am, pos, sel, len, top, al, hmo;
			int t;
			src = r.source_id;
			roff = r.req_offset;
			am = r.align_mask;
			hmo = r.hint_min_offset;
			pos = roff;
			sel = r.slot_hint;
			for (int k = 0; k < NSLOT; k++)
				if (owned(k, src)) cons[k] = roff;
			for (int k = 0; k < NSLOT; k++)
				if (!busy[k] && owned(k, src) && roff >= start[k] && roff < send[k]) begin
					o.status = ST_HIT;
					o.slot = 6'(k);
					o.data_offset = 24'(roff - start[k]);
					o.avail_size = 25'(send[k] - roff);
					return;
				end
			for (int k = 0; k < NSLOT; k++)
				if (busy[k] && owned(k, src) && roff >= start[k] && roff < start[k] + ext[k]) begin
					plan_valid = 0;
					o.status = ST_WAIT;
					o.slot = 6'(k);
					return;
				end
			if (hmo < roff && hmo + (chunk >> HINT_SPAN_SHIFT) > roff &&
					u64'(r.req_end) < (hmo & ~am) + chunk) begin
				pos = hmo;
				sel = r.hint_min_slot;
			end
			pos &= ~am;
			len = chunk;
			t = int'(sel % NSLOT);
			if (busy[t]) begin
				plan_valid = 0;
				o.status = ST_WAIT;
				o.slot = 6'(t);
				return;
			end
			for (int k = 0; k < NSLOT; k++) begin
				if (k == t || !owned(k, src)) continue;
				top = reach(k);
				if (start[k] > pos) begin
					if (start[k] - pos < len) len = start[k] - pos;
				end else if (top > pos) begin
					pos = (top & ~am) & M48;
				end
			end
			if (pos + len > u64'(r.source_last)) begin
				al = (u64'(r.source_last) + am) & ~am;
				if (al > pos && al - pos < len) len = al - pos;
			end
			claim(t, src, pos, len, roff);
			o.status = ST_PLANNED;
			o.slot = 6'(t);
		endfunction

		function void read_ahead(req_t r, ref rsp_t o);
			u64 src, am, last, pos, top, nxt, al, len;
			int t;
			bit found, moved, idle;
			src = r.source_id;
			am = r.align_mask;
			last = r.source_last;
			t = 0;
			found = 0;
			if (plan_valid) return;
			for (int k = 0; k < NSLOT; k++) begin
				idle = !busy[k] && (!used[k] || send[k] <= cons[k]);
				if (!idle) continue;
				if (!found || (!has_buf[t] && has_buf[k])) begin
					t = k;
					found = 1;
				end
			end
			if (!found) return;
			pos = u64'(r.req_offset) & ~am;
			for (int pass = 0; ; pass++) begin
				if (pass > NSLOT) return;
				moved = 0;
				for (int k = 0; k < NSLOT; k++) begin
					if (k == t || !owned(k, src)) continue;
					top = reach(k);
					if (start[k] <= pos && pos < top) begin
						nxt = (top & ~am) & M48;
						if (nxt <= pos) return;
						pos = nxt;
						moved = 1;
					end
				end
				if (!moved) break;
			end
			if (pos >= last) return;
			al = (last + am) & ~am;
			len = al - pos;
			if (chunk < len) len = chunk;
			for (int k = 0; k < NSLOT; k++)
				if (k != t && owned(k, src) && start[k] > pos && start[k] - pos < len)
					len = start[k] - pos;
			if (len == 0) return;
			claim(t, src, pos, len, r.req_offset);
			o.status = ST_PLANNED;
			o.slot = 6'(t);
		endfunction

		function rsp_t predict(req_t r);
			rsp_t o;
			int p;
			o = '0;
			o.status = ST_DECLINED;
			case (r.op)
				OP_LOOKUP: lookup(r, o);
				OP_AHEAD: read_ahead(r, o);
				OP_ISSUE: begin
					if (plan_valid) begin
						p = plan_slot % NSLOT;
						o.status = ST_ISSUED;
						o.slot = 6'(p);
						o.read_source = used[p] ? 8'(owner[p]) : 8'd0;
						o.read_offset = 48'(start[p]);
						o.rd_size = 25'(ext[p]);
						o.use_own_buffer = reuse && has_buf[p];
						busy[p] = 1;
						plan_valid = 0;
					end
				end
				OP_COMPLETE: begin
					o.status = ST_DONE;
					o.slot = r.done_slot;
					if (r.done_slot < NSLOT) begin
						has_buf[r.done_slot] = r.landed_has_buffer;
						ext[r.done_slot] = r.landed_size;
						send[r.done_slot] = (start[r.done_slot] + r.landed_size) & M48;
						busy[r.done_slot] = 0;
					end
				end
				OP_RELEASE: begin
					for (int k = 0; k < NSLOT; k++)
						if (!busy[k]) begin
							used[k] = 0; owner[k] = 0; start[k] = 0;
							send[k] = 0; cons[k] = 0;
						end
					o.status = ST_DONE;
				end
				default: ;
			endcase
			return o;
		endfunction

		function void note_request(req_t r);
			rsp_t o;
			o = predict(r);
			case (o.status)
				ST_HIT: hits++;
				ST_WAIT: waits++;
				ST_PLANNED: plans++;
				ST_ISSUED: issues++;
				default: ;
			endcase
			expected_rsp.push_back(o);
		endfunction

		task report_mismatch(string what, u64 got, u64 want);
			errors++;
			$display("%t mismatch %s: got %h, want %h", $realtime, what, got, want);
		endtask

		task check_response(rsp_t got);
			rsp_t w;
			if (expected_rsp.size() == 0) begin
				report_mismatch("unexpected transfer", u64'(got.status), 0);
				return;
			end
			w = expected_rsp.pop_front();
			checked++;
			if (got.status !== w.status) report_mismatch("status", got.status, w.status);
			if (got.slot !== w.slot) report_mismatch("slot", got.slot, w.slot);
			if (got.data_offset !== w.data_offset)
				report_mismatch("data_offset", got.data_offset, w.data_offset);
			if (got.avail_size !== w.avail_size)
				report_mismatch("avail_size", got.avail_size, w.avail_size);
			if (got.read_source !== w.read_source)
				report_mismatch("read_source", got.read_source, w.read_source);
			if (got.read_offset !== w.read_offset)
				report_mismatch("read_offset", got.read_offset, w.read_offset);
			if (got.rd_size !== w.rd_size)
				report_mismatch("rd_size", got.rd_size, w.rd_size);
			if (got.use_own_buffer !== w.use_own_buffer)
				report_mismatch("use_own_buffer", got.use_own_buffer, w.use_own_buffer);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	brrc_if #(req_t) req_ch ();
	brrc_if #(rsp_t) rsp_ch ();

	byte_range_read_cache_slots_core uut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	slot_table_tracker table_model = new();
	int item_count = 0;
	bit quiet = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	initial begin
		req_ch.valid = 0;
		req_ch.data = '0;
		rsp_ch.ready = 0;
	end

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_ch.ready <= 0;
			stall_left--;
		end else begin
			rsp_ch.ready <= 1;
			if (!quiet && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 19);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			table_model.check_response(rsp_ch.data);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| psel) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	task automatic send(req_t x);
		req_ch.data <= x;
		req_ch.valid <= 1;
		do @(posedge clk); while (!req_ch.ready);
		table_model.note_request(x);
		item_count++;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			req_ch.valid <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic write_reg(reg_t idx, logic [31:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 3'(4 * idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == REG_CHUNK) table_model.chunk = value[24:0];
		else table_model.reuse = value[0];
	endtask

	task automatic settle();
		req_ch.valid <= 0;
		while (table_model.expected_rsp.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic u64 rand48();
		return {$urandom, $urandom} & M48;
	endfunction

	function automatic logic [15:0] pick_mask();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'h000F;
			2: return 16'h0FFF;
			3: return 16'hFFFF;
			default: return 16'((32'd1 << $urandom_range(0, 16)) - 1);
		endcase
	endfunction

	function automatic req_t base_item(op_t op);
		req_t r;
		u64 off;
		r = '0;
		r.op = op;
		r.source_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		off = ($urandom_range(0, 15) == 0) ? rand48() : u64'($urandom_range(0, 1 << 20));
		r.req_offset = 48'(off);
		r.req_end = 48'(off + $urandom_range(0, 65536));
		r.slot_hint = 8'($urandom);
		r.hint_min_offset = (off > 70000 && $urandom_range(0, 1)) ?
			48'(off - $urandom_range(0, 70000)) : 48'(rand48());
		r.hint_min_slot = 8'($urandom);
		r.align_mask = pick_mask();
		r.source_last = ($urandom_range(0, 7) == 0) ? 48'(rand48())
			: 48'(off + $urandom_range(0, 1 << 20));
		r.done_slot = 6'($urandom);
		r.landed_size = 25'($urandom);
		r.landed_has_buffer = 1'($urandom);
		return r;
	endfunction

	function automatic req_t completion_of(int p);
		req_t r;
		r = base_item(OP_COMPLETE);
		r.done_slot = 6'(p);
		case ($urandom_range(0, 3))
			0, 1: r.landed_size = 25'(table_model.ext[p]);
			2: r.landed_size = 25'($urandom_range(0, int'(table_model.ext[p])));
			default: r.landed_size = 0;
		endcase
		return r;
	endfunction

	task automatic plan_and_land();
		req_t r;
		int p;
		send(base_item($urandom_range(0, 1) ? OP_LOOKUP : OP_AHEAD));
		if (!table_model.plan_valid) return;
		p = table_model.plan_slot;
		send(base_item(OP_ISSUE));
		if ($urandom_range(0, 2) == 0) begin
			r = base_item(OP_LOOKUP);
			r.source_id = 8'(table_model.owner[p]);
			r.req_offset = 48'(table_model.start[p]);
			send(r);
		end
		if (table_model.busy[p]) send(completion_of(p));
	endtask

	task automatic hit_lookup();
		req_t r;
		int p;
		p = $urandom_range(0, NSLOT - 1);
		r = base_item(OP_LOOKUP);
		if (table_model.used[p]) begin
			r.source_id = 8'(table_model.owner[p]);
			r.req_offset = 48'((table_model.start[p] +
				(table_model.ext[p] == 0 ? 0 : $urandom % table_model.ext[p])) & M48);
		end
		send(r);
	endtask

	task automatic random_phase(int n);
		req_t r;
		int goal;
		goal = item_count + n;
		while (item_count < goal) begin
			if (item_count > 800) quiet = 1;
			case ($urandom_range(0, 19))
				0: send(base_item(OP_RELEASE));
				1, 2: begin
					r = base_item(op_t'($urandom_range(0, 7)));
					send(r);
				end
				3, 4, 5, 6: hit_lookup();
				default: plan_and_land();
			endcase
		end
	endtask

	task automatic directed();
		req_t r;
		r = base_item(OP_LOOKUP);
		r.source_id = 0; r.req_offset = 0; r.align_mask = 0; r.source_last = 1000;
		r.slot_hint = 2; r.hint_min_offset = 0;
		send(r);
		send(base_item(OP_ISSUE));
		send(base_item(OP_ISSUE));
		r.req_offset = 10;
		send(r);
		r = completion_of(2); r.landed_has_buffer = 1;
		send(r);
		r = base_item(OP_LOOKUP);
		r.source_id = 0; r.req_offset = 5;
		send(r);
		r = base_item(OP_AHEAD);
		r.source_id = 0; r.req_offset = 0; r.align_mask = 16'h00FF; r.source_last = 5000;
		send(r);
		send(r);
		send(base_item(OP_ISSUE));
		r = '1;
		send(r);
		r.op = OP_COMPLETE;
		send(r);
		r.op = OP_LOOKUP;
		send(r);
		send(base_item(OP_ISSUE));
		r.op = OP_AHEAD;
		send(r);
		r = '0; r.op = OP_COMPLETE; r.done_slot = 3; r.landed_size = 25'd16777216;
		send(r);
		r.landed_size = 25'hFF_FFFF; r.done_slot = 7;
		send(r);
		r = '0; r.op = 3'd5;
		send(r);
		r.op = 3'd6;
		send(r);
		send(base_item(OP_RELEASE));
		send(base_item(OP_ISSUE));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed();
		random_phase(140);
		settle();
		write_reg(REG_CHUNK, 32'd1);
		write_reg(REG_REUSE, 32'd0);
		random_phase(130);
		settle();
		write_reg(REG_CHUNK, 32'd16777216);
		write_reg(REG_REUSE, 32'd1);
		random_phase(130);
		settle();
		write_reg(REG_CHUNK, 32'd4096);
		random_phase(130);
		settle();
		write_reg(REG_CHUNK, 32'd64);
		write_reg(REG_REUSE, 32'd0);
		random_phase(130);
		settle();
		write_reg(REG_CHUNK, $urandom_range(1, 1 << 18));
		write_reg(REG_REUSE, 32'd1);
		random_phase(270);
		settle();
		$display("%0d requests checked over six register settings:", table_model.checked);
		$display("  %0d hits, %0d waits, %0d planned, %0d issued", table_model.hits,
			table_model.waits, table_model.plans, table_model.issues);
		if (table_model.errors == 0 && table_model.expected_rsp.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
